>>> hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the detector.
// Needs nothing else; take it in with `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: ante |-> cons");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: ante |=> cons");

`endif

>>> hw/rtl/sted_pkg.sv
// Types, constants and the trigger evaluation function of the sensor trigger event detector.
// Depends on nothing.
package sted_pkg;

    localparam int unsigned SAMPLE_W  = 8;
    localparam int unsigned HOLD_W    = 7;
    localparam int unsigned CODE_W    = 8;
    localparam int unsigned SENSOR_W  = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned WORD_W    = 27;

    localparam logic [HOLD_W-1:0] EDGE_GATE        = 7'd20;
    localparam logic [HOLD_W-1:0] HELD_ABOVE_STEPS = 7'd50;
    localparam logic [HOLD_W-1:0] HELD_BELOW_STEPS = 7'd100;
    localparam logic [HOLD_W-1:0] HOLD_MAX         = 7'd127;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [HOLD_W-1:0]   t_hold;

    typedef enum logic [2:0] {
        MODE_RISE       = 3'd0,
        MODE_FALL       = 3'd1,
        MODE_ABOVE      = 3'd2,
        MODE_BELOW      = 3'd3,
        MODE_HELD_ABOVE = 3'd4,
        MODE_HELD_BELOW = 3'd5
    } t_mode;

    typedef struct packed {
        logic [CODE_W-1:0] detail;
        logic [CODE_W-1:0] response;
        t_sample           level;
        t_mode             mode;
    } t_trig;

    typedef struct packed {
        logic  fire;
        t_hold hold;
    } t_eval;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] detail;
        logic              last;
    } t_result;

    function automatic t_hold held_next(input logic cond, input t_hold hc);
        t_hold nh;
        nh = hc;
        if (cond) begin
            if (hc < HOLD_MAX) begin
                nh = hc + 7'd1;
            end
        end else if (hc != '0) begin
            nh = hc - 7'd1;
        end
        return nh;
    endfunction

    function automatic t_eval trig_eval(input t_trig w, input t_sample prev,
                                        input t_sample cur, input t_hold hc);
        t_eval r;
        logic  above;
        logic  below;
        above  = cur > w.level;
        below  = cur < w.level;
        r.fire = 1'b0;
        r.hold = hc;
        if (w.response != '0) begin
            case (w.mode)
                MODE_RISE:  r.fire = (prev < w.level) && above && (hc < EDGE_GATE);
                MODE_FALL:  r.fire = (prev > w.level) && below && (hc < EDGE_GATE);
                MODE_ABOVE: r.fire = above;
                MODE_BELOW: r.fire = below;
                MODE_HELD_ABOVE: begin
                    if (above && hc >= HELD_ABOVE_STEPS) begin
                        r.fire = 1'b1;
                        r.hold = '0;
                    end else begin
                        r.hold = held_next(above, hc);
                    end
                end
                MODE_HELD_BELOW: begin
                    if (below && hc >= HELD_BELOW_STEPS) begin
                        r.fire = 1'b1;
                        r.hold = '0;
                    end else begin
                        r.hold = held_next(below, hc);
                    end
                end
                default: r.fire = 1'b0;
            endcase
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/sensor_trigger_event_detector.sv
// A sample beat is accepted into the input register; its results are written to the result
// queue once there is room and are shown on the output from the queue. The input takes one beat
// per cycle while the queue has room; a beat that fires both triggers gives two result beats.
// Reset (synchronous, active low) clears trigger words, sample and hold state, the input
// valid flag and the pointers and count of the 4-entry result queue; no clearing pass.
// Top level of the sensor trigger event detector; uses sted_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sensor_trigger_event_detector #(
    parameter int unsigned SENSOR_COUNT        = 4,
    parameter int unsigned TRIGGERS_PER_SENSOR = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [sted_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sted_pkg::WORD_W-1:0]       i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [sted_pkg::SENSOR_W-1:0]     i_sensor_index,
    input  logic [sted_pkg::SAMPLE_W-1:0]     i_sample_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [sted_pkg::CODE_W-1:0]       o_response_code,
    output logic [sted_pkg::CODE_W-1:0]       o_response_detail,
    output logic                              o_last_of_run
);

    localparam int unsigned SEL_W   = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int unsigned TRIG_SLOTS = 4;
    localparam logic [2:0]  Q_DEPTH = 3'd4;
    localparam logic [2:0]  Q_ROOM  = 3'd2;

    logic [sted_pkg::WORD_W-1:0] r_trig_t0 [TRIG_SLOTS];
    logic [sted_pkg::WORD_W-1:0] r_trig_t1 [TRIG_SLOTS];

    sted_pkg::t_sample r_prev   [SENSOR_COUNT];
    sted_pkg::t_sample r_latest [SENSOR_COUNT];
    sted_pkg::t_hold   r_hold   [SENSOR_COUNT];

    logic                            r_in_valid;
    logic [sted_pkg::SENSOR_W-1:0]   r_sensor;
    sted_pkg::t_sample               r_sample;

    sted_pkg::t_result r_queue [4];
    logic [1:0]        r_rd_ptr;
    logic [1:0]        r_wr_ptr;
    logic [2:0]        r_count;

    logic              sensor_ok;
    logic [SEL_W-1:0]  sel;
    sted_pkg::t_trig   trig0;
    sted_pkg::t_trig   trig1;
    sted_pkg::t_sample prev_cur;
    sted_pkg::t_hold   hold_cur;
    sted_pkg::t_eval   ev0;
    sted_pkg::t_eval   ev1;
    logic              fire0;
    logic              fire1;
    logic              pop;
    logic              process;
    logic [2:0]        n_count;
    logic [1:0]        push_n;
    sted_pkg::t_result res0;
    sted_pkg::t_result res1;
    sted_pkg::t_result head;

    assign sensor_ok = ({1'b0, r_sensor} < 3'(SENSOR_COUNT));
    assign sel       = SEL_W'(r_sensor);
    assign prev_cur  = sensor_ok ? r_latest[sel] : '0;
    assign hold_cur  = sensor_ok ? r_hold[sel] : '0;
    assign trig0     = sted_pkg::t_trig'(r_trig_t0[r_sensor]);
    assign trig1     = (TRIGGERS_PER_SENSOR > 1) ?
                       sted_pkg::t_trig'(r_trig_t1[r_sensor]) : '0;

    // trigger 1 sees the hold count left by trigger 0
    assign ev0   = sted_pkg::trig_eval(trig0, prev_cur, r_sample, hold_cur);
    assign ev1   = sted_pkg::trig_eval(trig1, prev_cur, r_sample, ev0.hold);
    assign fire0 = ev0.fire && sensor_ok;
    assign fire1 = ev1.fire && sensor_ok;

    assign head              = r_queue[r_rd_ptr];
    assign o_out_valid       = (r_count != '0);
    assign o_response_code   = head.code;
    assign o_response_detail = head.detail;
    assign o_last_of_run     = head.last;

    assign pop        = o_out_valid && i_out_ready;
    assign process    = r_in_valid && ((r_count - {2'b0, pop}) <= Q_ROOM);
    assign o_in_ready = !r_in_valid || process;

    always_comb begin
        res0 = '0;
        res1 = '0;
        if (fire0) begin
            res0.code   = trig0.response;
            res0.detail = trig0.detail;
            res0.last   = !fire1;
            res1.code   = trig1.response;
            res1.detail = trig1.detail;
            res1.last   = 1'b1;
        end else begin
            res0.code   = trig1.response;
            res0.detail = trig1.detail;
            res0.last   = 1'b1;
        end
        push_n  = process ? (2'({1'b0, fire0}) + 2'({1'b0, fire1})) : 2'd0;
        n_count = r_count - {2'b0, pop} + {1'b0, push_n};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TRIG_SLOTS; i++) begin
                r_trig_t0[i] <= '0;
                r_trig_t1[i] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index[0]) begin
                r_trig_t1[i_cfg_index[2:1]] <= i_cfg_wdata;
            end else begin
                r_trig_t0[i_cfg_index[2:1]] <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                r_prev[i]   <= '0;
                r_latest[i] <= '0;
                r_hold[i]   <= '0;
            end
        end else if (process && sensor_ok) begin
            r_prev[sel]   <= r_latest[sel];
            r_latest[sel] <= r_sample;
            r_hold[sel]   <= ev1.hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_sensor <= i_sensor_index;
            r_sample <= i_sample_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            r_wr_ptr <= r_wr_ptr + push_n;
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_n != '0) begin
            r_queue[r_wr_ptr] <= res0;
        end
        if (push_n == 2'd2) begin
            r_queue[r_wr_ptr + 2'd1] <= res1;
        end
    end

    `ASSERT_IMPLIES(a_queue_bound, i_clk, i_rst_n, 1'b1, r_count <= Q_DEPTH)
    `ASSERT_IMPLIES(a_pair_queued, i_clk, i_rst_n, o_out_valid && !o_last_of_run, r_count >= 3'd2)
    `ASSERT_IMPLIES(a_hold_range, i_clk, i_rst_n, r_in_valid && sensor_ok, hold_cur <= sted_pkg::HELD_BELOW_STEPS)
    `ASSERT_NEXT(a_beat_lands, i_clk, i_rst_n, i_in_valid && o_in_ready, r_in_valid)

endmodule

>>> verif/sensor_trigger_event_detector_tb.sv
// Self-checking testbench for sensor_trigger_event_detector: valid/ready driver and monitor,
// an in-bench predictor of trigger firing and hold counting, and a scoreboard of result beats.
// Depends on sted_pkg and the RTL of the detector.
module sensor_trigger_event_detector_tb;
    import sted_pkg::*;

    localparam int REG_COUNT = 8;
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;
    localparam int FLAVOR_HELD  = 1;
    localparam int FLAVOR_EDGE  = 2;
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        logic [SENSOR_W-1:0] sensor;
        t_sample             value;
    } t_sample_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [SENSOR_W-1:0] sensor_index = '0;
    t_sample sample_value = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [CODE_W-1:0] response_code;
    logic [CODE_W-1:0] response_detail;
    logic last_of_run;

    logic [WORD_W-1:0] trig_words [REG_COUNT];
    t_sample prev_sample [4];
    t_sample cur_sample [4];
    t_hold hold_cnt [4];
    logic side_up [4];

    t_sample_beat pending_beats[$];
    t_result expected_events[$];
    t_sample_beat next_beat;
    t_result want;
    logic no_idle = 1'b0;
    int beats_pushed = 0;
    int beats_accepted = 0;
    int results_checked = 0;
    int held_fires = 0;
    int settings_used = 0;
    int error_count = 0;

    sensor_trigger_event_detector u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (cfg_wr_en),
        .i_cfg_index       (cfg_index),
        .i_cfg_wdata       (cfg_wdata),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_sensor_index    (sensor_index),
        .i_sample_value    (sample_value),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_response_code   (response_code),
        .o_response_detail (response_detail),
        .o_last_of_run     (last_of_run)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void predict_events(input logic [SENSOR_W-1:0] s, input t_sample smp);
        t_result fired [2];
        int n;
        t_trig tw;
        t_sample p;
        t_sample c;
        logic fire;
        logic cond;
        t_hold thr;
        n = 0;
        prev_sample[s] = cur_sample[s];
        cur_sample[s] = smp;
        p = prev_sample[s];
        c = cur_sample[s];
        for (int t = 0; t < 2; t++) begin
            tw = trig_words[int'(s) * 2 + t];
            fire = 1'b0;
            if (tw.response != '0) begin
                case (tw.mode)
                    MODE_RISE:  fire = p < tw.level && c > tw.level && hold_cnt[s] < EDGE_GATE;
                    MODE_FALL:  fire = p > tw.level && c < tw.level && hold_cnt[s] < EDGE_GATE;
                    MODE_ABOVE: fire = c > tw.level;
                    MODE_BELOW: fire = c < tw.level;
                    MODE_HELD_ABOVE, MODE_HELD_BELOW: begin
                        cond = (tw.mode == MODE_HELD_ABOVE) ? c > tw.level : c < tw.level;
                        thr = (tw.mode == MODE_HELD_ABOVE) ? HELD_ABOVE_STEPS
                                                           : HELD_BELOW_STEPS;
                        if (cond && hold_cnt[s] >= thr) begin
                            fire = 1'b1;
                            hold_cnt[s] = '0;
                            held_fires++;
                        end else if (cond) begin
                            if (hold_cnt[s] != HOLD_MAX) hold_cnt[s] = hold_cnt[s] + 7'd1;
                        end else if (hold_cnt[s] != '0) begin
                            hold_cnt[s] = hold_cnt[s] - 7'd1;
                        end
                    end
                    default: fire = 1'b0;
                endcase
            end
            if (fire) begin
                fired[n] = '{code: tw.response, detail: tw.detail, last: 1'b0};
                n++;
            end
        end
        for (int k = 0; k < n; k++) begin
            fired[k].last = (k == n - 1);
            expected_events.push_back(fired[k]);
        end
    endfunction

    function automatic logic [WORD_W-1:0] trig_word(input logic [2:0] md, input t_sample lvl,
                                                    input logic [7:0] resp,
                                                    input logic [7:0] det);
        return {det, resp, lvl, md};
    endfunction

    function automatic t_sample pick_sample(input logic [SENSOR_W-1:0] s, input int flavor);
        t_trig tw;
        logic go_up;
        int noise;
        tw = trig_words[int'(s) * 2];
        noise = (flavor == FLAVOR_HELD) ? 8 : 30;
        if (flavor == FLAVOR_EDGE) begin
            side_up[s] = ~side_up[s];
            go_up = side_up[s];
        end else begin
            go_up = tw.mode == MODE_RISE || tw.mode == MODE_ABOVE || tw.mode == MODE_HELD_ABOVE;
        end
        if ($urandom_range(99) < noise) return t_sample'($urandom_range(255));
        if (go_up && tw.level != 8'hFF) return t_sample'($urandom_range(int'(tw.level) + 1, 255));
        if (!go_up && tw.level != 8'h00) return t_sample'($urandom_range(0, int'(tw.level) - 1));
        return t_sample'($urandom_range(255));
    endfunction

    task automatic write_trig_word(input int idx, input logic [WORD_W-1:0] word);
        @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_wdata <= word;
        trig_words[idx] = word;
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic queue_beat(input logic [SENSOR_W-1:0] s, input t_sample v);
        pending_beats.push_back('{sensor: s, value: v});
        beats_pushed++;
    endtask

    task automatic wait_drained();
        while (beats_accepted != beats_pushed || expected_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input int flavor, input int beats);
        logic [2:0] md;
        t_sample lvl;
        logic [7:0] resp;
        logic [SENSOR_W-1:0] focus;
        logic [SENSOR_W-1:0] s;
        int roll;
        for (int r = 0; r < REG_COUNT; r++) begin
            if (flavor == FLAVOR_HELD && r % 2 == 0) md = 3'($urandom_range(4, 5));
            else if (flavor == FLAVOR_EDGE) md = 3'($urandom_range(0, 1));
            else md = 3'($urandom_range(7));
            roll = $urandom_range(7);
            lvl = (roll == 0) ? 8'h00 : (roll == 1) ? 8'hFF : t_sample'($urandom_range(255));
            resp = ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
            write_trig_word(r, trig_word(md, lvl, resp, 8'($urandom_range(255))));
        end
        end_writes();
        focus = SENSOR_W'($urandom_range(3));
        for (int i = 0; i < beats; i++) begin
            if (flavor == FLAVOR_HELD && $urandom_range(99) < 80) s = focus;
            else s = SENSOR_W'($urandom_range(3));
            queue_beat(s, pick_sample(s, flavor));
        end
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                predict_events(sensor_index, sample_value);
                beats_accepted++;
            end
            if (!in_valid || in_ready) begin
                if (pending_beats.size() != 0 && (no_idle || $urandom_range(99) >= 23)) begin
                    next_beat = pending_beats.pop_front();
                    in_valid <= 1'b1;
                    sensor_index <= next_beat.sensor;
                    sample_value <= next_beat.value;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                results_checked++;
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected result beat code %h detail %h last %b",
                             $time, response_code, response_detail, last_of_run);
                    error_count++;
                end else begin
                    want = expected_events.pop_front();
                    if (response_code !== want.code) begin
                        $display("%0t: response_code expected %h actual %h",
                                 $time, want.code, response_code);
                        error_count++;
                    end
                    if (response_detail !== want.detail) begin
                        $display("%0t: response_detail expected %h actual %h",
                                 $time, want.detail, response_detail);
                        error_count++;
                    end
                    if (last_of_run !== want.last) begin
                        $display("%0t: last_of_run expected %b actual %b",
                                 $time, want.last, last_of_run);
                        error_count++;
                    end
                end
            end
            out_ready <= no_idle || $urandom_range(99) >= 23;
        end
    end

    initial begin
        for (int i = 0; i < 4; i++) begin
            prev_sample[i] = '0;
            cur_sample[i] = '0;
            hold_cnt[i] = '0;
            side_up[i] = 1'b0;
        end
        for (int r = 0; r < REG_COUNT; r++) trig_words[r] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every mode, both spare modes, sample extremes, counting down at zero
        write_trig_word(0, trig_word(MODE_RISE, 8'd100, 8'h01, 8'h00));
        write_trig_word(1, trig_word(MODE_FALL, 8'd100, 8'hFF, 8'hFF));
        write_trig_word(2, trig_word(MODE_ABOVE, 8'd0, 8'h11, 8'h22));
        write_trig_word(3, trig_word(MODE_BELOW, 8'd255, 8'h33, 8'h44));
        write_trig_word(4, trig_word(MODE_HELD_ABOVE, 8'd10, 8'h55, 8'h66));
        write_trig_word(5, trig_word(MODE_SPARE_A, 8'd0, 8'h77, 8'h88));
        write_trig_word(6, trig_word(MODE_HELD_BELOW, 8'd200, 8'h99, 8'hAA));
        write_trig_word(7, trig_word(MODE_SPARE_B, 8'd255, 8'hCC, 8'hDD));
        end_writes();
        queue_beat(2'd0, 8'd50);
        queue_beat(2'd0, 8'd150);
        queue_beat(2'd0, 8'd100);
        queue_beat(2'd0, 8'd150);
        queue_beat(2'd0, 8'd20);
        queue_beat(2'd0, 8'd255);
        queue_beat(2'd0, 8'd0);
        queue_beat(2'd1, 8'd0);
        queue_beat(2'd1, 8'd255);
        queue_beat(2'd1, 8'd128);
        queue_beat(2'd2, 8'd0);
        queue_beat(2'd2, 8'd255);
        queue_beat(2'd2, 8'd5);
        queue_beat(2'd2, 8'd11);
        queue_beat(2'd3, 8'd255);
        queue_beat(2'd3, 8'd0);
        queue_beat(2'd3, 8'd199);
        queue_beat(2'd3, 8'd200);
        wait_drained();

        // all triggers disabled, then every word bit set
        for (int r = 0; r < REG_COUNT; r++) write_trig_word(r, '0);
        end_writes();
        for (int i = 0; i < 60; i++) queue_beat(SENSOR_W'($urandom_range(3)), 8'($urandom));
        wait_drained();
        for (int r = 0; r < REG_COUNT; r++) write_trig_word(r, '1);
        end_writes();
        for (int i = 0; i < 60; i++) queue_beat(SENSOR_W'($urandom_range(3)), 8'($urandom));
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            no_idle = (ph == 4);
            run_phase(ph % 3, (ph % 3 == FLAVOR_HELD) ? 250 : 170);
        end

        $display("Checked %0d result beats from %0d sample beats over %0d trigger settings;",
                 results_checked, beats_accepted, settings_used);
        $display("held triggers fired %0d times.", held_fires);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
